@@ design/hcva_pkg.sv @@
// Shared types, constants and helpers for the hex cell vertex assembler.
package hcva_pkg;

   localparam int FieldBits        = 32;
   localparam int IndexBitsDefault = 32;
   localparam int NumVerts         = 8;
   localparam int NumSlots         = 6;
   localparam int FaceNodes        = 4;
   localparam int SlotBits         = 3;
   localparam int VertBits         = 3;
   localparam int CountBits        = 3;
   localparam int ReqDataBits      = 232;
   localparam int RspDataBits      = 296;

   localparam logic [FieldBits-1:0] CellIndexReset = 32'd1;

   typedef enum logic [3:0] {
      ST_OK           = 4'd0,
      ST_NOT_QUAD     = 4'd1,
      ST_NOT_ADJ      = 4'd2,
      ST_OVER_SIX     = 4'd3,
      ST_PAIR_MISSING = 4'd4,
      ST_CLASH        = 4'd5,
      ST_BAD_CONN     = 4'd6,
      ST_NO_MATCH     = 4'd7,
      ST_DUP          = 4'd8
   } status_type;

   typedef struct packed {
      logic [FieldBits-1:0] node_d;
      logic [FieldBits-1:0] node_c;
      logic [FieldBits-1:0] node_b;
      logic [FieldBits-1:0] node_a;
      logic [FieldBits-1:0] neighbour_cell;
      logic [FieldBits-1:0] owner_cell;
      logic                 is_quad;
      logic [FieldBits-1:0] face_id;
   } face_item_type;

   typedef struct packed {
      status_type           status;
      logic [SlotBits-1:0]  face_slot;
      logic [FieldBits-1:0] other_cell;
   } face_result_type;

   // first set position of a four-bit match vector
   function automatic logic [1:0] first_pos(input logic [FaceNodes-1:0] hits);
      logic [1:0] pos;
      pos = 2'd0;
      priority if (hits[0]) pos = 2'd0;
      else if (hits[1])     pos = 2'd1;
      else if (hits[2])     pos = 2'd2;
      else                  pos = 2'd3;
      return pos;
   endfunction

endpackage

@@ design/hcva_classify.sv @@
// Face classification, checking and vertex update for one face transaction.
module hcva_classify import hcva_pkg::*; #(
   parameter int INDEX_BITS = IndexBitsDefault,
   localparam int CmpBits = (INDEX_BITS < FieldBits) ? INDEX_BITS : FieldBits
) (
   input  face_item_type        item,
   input  logic [FieldBits-1:0] cell_index,
   input  logic [CountBits-1:0] faces_seen,
   input  logic [CmpBits-1:0]   verts [NumVerts],
   input  logic [NumSlots-1:0]  slot_taken,
   output face_result_type      result,
   output logic [CmpBits-1:0]   verts_in [NumVerts],
   output logic [NumSlots-1:0]  slot_taken_in,
   output logic [CountBits-1:0] faces_seen_in
);

   logic [CmpBits-1:0]   me, c0, c1;
   logic [CmpBits-1:0]   n [FaceNodes];
   logic [FaceNodes-1:0] hit0, hit3, hit4, hit7, hit_any;
   logic [1:0]           p0, p7, q3, q4;
   logic                 own;
   logic [CmpBits-1:0]   other;

   assign me   = cell_index[CmpBits-1:0];
   assign c0   = item.owner_cell[CmpBits-1:0];
   assign c1   = item.neighbour_cell[CmpBits-1:0];
   assign n[0] = item.node_a[CmpBits-1:0];
   assign n[1] = item.node_b[CmpBits-1:0];
   assign n[2] = item.node_c[CmpBits-1:0];
   assign n[3] = item.node_d[CmpBits-1:0];
   assign own   = (me == c0);
   assign other = own ? c1 : c0;

   always_comb begin
      for (int i = 0; i < FaceNodes; i++) begin
         hit0[i] = (n[i] == verts[0]);
         hit3[i] = (n[i] == verts[3]);
         hit4[i] = (n[i] == verts[4]);
         hit7[i] = (n[i] == verts[7]);
      end
   end

   assign hit_any = hit0 | hit3 | hit4 | hit7;
   assign p0 = first_pos(hit0);
   assign p7 = first_pos(hit7);
   assign q3 = first_pos(hit3);
   assign q4 = first_pos(hit4);

   always_comb begin
      logic [2:0]          cnt;
      logic [1:0]          ia, ib, ia_f, ia_b, ib_f, ib_b;
      logic [VertBits-1:0] va, vb;
      logic [CmpBits-1:0]  xa, xb;
      logic [SlotBits-1:0] slot;
      status_type          st;
      cnt  = 3'($countones(hit_any));
      ia   = 2'd0;
      ib   = 2'd0;
      va   = '0;
      vb   = '0;
      slot = '0;
      st   = ST_OK;
      verts_in      = verts;
      slot_taken_in = slot_taken;
      faces_seen_in = faces_seen;

      // pick the two anchor positions of a side face
      priority if (|hit0 && |hit4) begin
         slot = 3'd2; va = 3'd5; vb = 3'd1; ia = q4; ib = p0;
      end else if (|hit0 && |hit3) begin
         slot = 3'd4; va = 3'd1; vb = 3'd2; ia = p0; ib = q3;
      end else if (|hit0) begin
         st = ST_PAIR_MISSING;
      end else if (|hit7 && |hit4) begin
         slot = 3'd5; va = 3'd6; vb = 3'd5; ia = p7; ib = q4;
      end else if (|hit7 && |hit3) begin
         slot = 3'd3; va = 3'd2; vb = 3'd6; ia = q3; ib = p7;
      end else if (|hit7) begin
         st = ST_PAIR_MISSING;
      end else begin
         st = ST_BAD_CONN;
      end

      ia_f = ia + 2'd1;
      ia_b = ia - 2'd1;
      ib_f = ib + 2'd1;
      ib_b = ib - 2'd1;
      xa = own ? n[ia_f] : n[ia_b];
      xb = own ? n[ib_b] : n[ib_f];

      if (st == ST_OK && !((verts[va] == '0) || (verts[va] == xa)
                           && 1'b1) ) begin
         st = ST_CLASH;
      end else if (st == ST_OK && !((verts[vb] == '0) || (verts[vb] == xb))) begin
         st = ST_CLASH;
      end

      result.status     = ST_OK;
      result.face_slot  = '0;
      result.other_cell = '0;

      priority if (!item.is_quad) begin
         result.status = ST_NOT_QUAD;
      end else if (me != c0 && me != c1) begin
         result.status = ST_NOT_ADJ;
      end else if (faces_seen >= CountBits'(NumSlots)) begin
         result.status = ST_OVER_SIX;
      end else if (faces_seen == '0) begin
         // first face seeds the bottom quad
         verts_in[0] = n[0];
         verts_in[7] = n[2];
         verts_in[3] = own ? n[1] : n[3];
         verts_in[4] = own ? n[3] : n[1];
         verts_in[1] = '0;
         verts_in[2] = '0;
         verts_in[5] = '0;
         verts_in[6] = '0;
         slot_taken_in    = NumSlots'(1);
         faces_seen_in    = faces_seen + CountBits'(1);
         result.other_cell = FieldBits'(other);
      end else if (cnt == 3'd0) begin
         if (slot_taken[1]) begin
            result.status = ST_DUP;
         end else begin
            slot_taken_in[1]  = 1'b1;
            faces_seen_in     = faces_seen + CountBits'(1);
            result.face_slot  = 3'd1;
            result.other_cell = FieldBits'(other);
         end
      end else if (cnt == 3'd2) begin
         if (st != ST_OK) begin
            result.status = st;
         end else if (slot_taken[slot]) begin
            result.status = ST_DUP;
         end else begin
            if (verts[va] == '0) verts_in[va] = xa;
            if (verts[vb] == '0) verts_in[vb] = xb;
            slot_taken_in[slot] = 1'b1;
            faces_seen_in       = faces_seen + CountBits'(1);
            result.face_slot    = slot;
            result.other_cell   = FieldBits'(other);
         end
      end else begin
         result.status = ST_NO_MATCH;
      end
   end

endmodule

@@ design/hcva_state.sv @@
// Cell assembly state: index register, face count, vertices and slot flags.
module hcva_state import hcva_pkg::*; #(
   parameter int INDEX_BITS = IndexBitsDefault,
   localparam int CmpBits = (INDEX_BITS < FieldBits) ? INDEX_BITS : FieldBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [FieldBits-1:0] csr_wr_data,
   input  logic                 commit,
   input  logic [CmpBits-1:0]   verts_in [NumVerts],
   input  logic [NumSlots-1:0]  slot_taken_in,
   input  logic [CountBits-1:0] faces_seen_in,
   output logic [FieldBits-1:0] cell_index,
   output logic [CmpBits-1:0]   verts [NumVerts],
   output logic [NumSlots-1:0]  slot_taken,
   output logic [CountBits-1:0] faces_seen
);

   logic [FieldBits-1:0] cell_index_ff;
   logic [CmpBits-1:0]   verts_ff [NumVerts];
   logic [NumSlots-1:0]  slot_taken_ff;
   logic [CountBits-1:0] faces_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_index_ff <= CellIndexReset;
         faces_seen_ff <= '0;
         slot_taken_ff <= '0;
         for (int i = 0; i < NumVerts; i++) verts_ff[i] <= '0;
      end else if (csr_wr_en) begin
         // restart assembly under the new index
         cell_index_ff <= csr_wr_data;
         faces_seen_ff <= '0;
         slot_taken_ff <= '0;
         for (int i = 0; i < NumVerts; i++) verts_ff[i] <= '0;
      end else if (commit) begin
         faces_seen_ff <= faces_seen_in;
         slot_taken_ff <= slot_taken_in;
         verts_ff      <= verts_in;
      end
   end

   assign cell_index = cell_index_ff;
   assign verts      = verts_ff;
   assign slot_taken = slot_taken_ff;
   assign faces_seen = faces_seen_ff;

endmodule

@@ design/hex_cell_vertex_assembler.sv @@
// Hex cell vertex assembler: face stream in, per-face status and vertices out.
//
// Faces of one hexahedral cell enter on the req_ stream, one face per
// transaction; each face yields exactly one rsp_ transaction with its status,
// slot, far-side cell, completion flag and the eight vertices after the face.
// The cell index is loaded through csr_wr_en/csr_wr_data; a write restarts
// assembly and must be issued only while no face is in flight, which the
// block itself does not enforce. A face passes the req_ input register, then
// classification and state update into the result register, which sets
// rsp_tvalid; it loads once empty or once rsp_tready takes its old result.
// Throughput is one face per cycle while rsp_tready does not stall; the
// vertex/slot state is read and written in the same cycle, so each face sees
// the state left by the one before. A stalled rsp_tready holds both registers;
// req_ takes a face while the input register is empty or the result one drains.
// Synchronous reset clears both registers' valid flags, sets the cell index
// to one and clears the face count, vertices and slot flags.
module hex_cell_vertex_assembler import hcva_pkg::*; #(
   parameter int INDEX_BITS = IndexBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [FieldBits-1:0]   csr_wr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // face_id, is_quad, owner_cell, neighbour_cell, node_a..node_d, zero pad
   input  logic [ReqDataBits-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status, face_slot, other_cell, complete, vert0..vert7
   output logic [RspDataBits-1:0] rsp_tdata
);

   localparam int CmpBits = (INDEX_BITS < FieldBits) ? INDEX_BITS : FieldBits;

   face_item_type        req_ff, req_in;
   logic                 req_valid_ff, req_valid_in;
   logic [RspDataBits-1:0] rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 fire;

   face_result_type      result;
   logic [FieldBits-1:0] cell_index;
   logic [CmpBits-1:0]   verts [NumVerts];
   logic [CmpBits-1:0]   verts_in [NumVerts];
   logic [NumSlots-1:0]  slot_taken, slot_taken_in;
   logic [CountBits-1:0] faces_seen, faces_seen_in;
   logic                 complete;

   assign fire       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || fire;

   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff;
      if (req_tvalid && req_tready) begin
         req_in       = face_item_type'(req_tdata[$bits(face_item_type)-1:0]);
         req_valid_in = 1'b1;
      end else if (fire) begin
         req_valid_in = 1'b0;
      end
   end

   hcva_classify #(.INDEX_BITS(INDEX_BITS)) u_classify (
      .item          (req_ff),
      .cell_index    (cell_index),
      .faces_seen    (faces_seen),
      .verts         (verts),
      .slot_taken    (slot_taken),
      .result        (result),
      .verts_in      (verts_in),
      .slot_taken_in (slot_taken_in),
      .faces_seen_in (faces_seen_in)
   );

   hcva_state #(.INDEX_BITS(INDEX_BITS)) u_state (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .commit        (fire && result.status == ST_OK),
      .verts_in      (verts_in),
      .slot_taken_in (slot_taken_in),
      .faces_seen_in (faces_seen_in),
      .cell_index    (cell_index),
      .verts         (verts),
      .slot_taken    (slot_taken),
      .faces_seen    (faces_seen)
   );

   assign complete = (result.status == ST_OK) ?
                     (faces_seen_in == CountBits'(NumSlots)) :
                     (faces_seen == CountBits'(NumSlots));

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_in = {FieldBits'(verts_in[7]), FieldBits'(verts_in[6]),
                   FieldBits'(verts_in[5]), FieldBits'(verts_in[4]),
                   FieldBits'(verts_in[3]), FieldBits'(verts_in[2]),
                   FieldBits'(verts_in[1]), FieldBits'(verts_in[0]),
                   complete, result.other_cell, result.face_slot,
                   result.status};
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

@@ verif/hex_cell_vertex_assembler_test.sv @@
// Self-checking testbench for the hex cell vertex assembler with its own cell model.
module hex_cell_vertex_assembler_test;
   import hcva_pkg::*;

   localparam int ItemsPerPhase  = 375;
   localparam int FaultPct       = 25;
   localparam int PressureCycles = 400;
   localparam int WatchdogLimit  = 3000;
   localparam int DrainCycles    = 4;
   localparam int SettleCycles   = 8;
   localparam int MaxPrinted     = 100;

   typedef logic [FaceNodes-1:0][FieldBits-1:0] face_ring_type;
   typedef logic [NumVerts-1:0][FieldBits-1:0]  cell_nodes_type;

   typedef struct packed {
      cell_nodes_type       verts;
      logic                 complete;
      logic [FieldBits-1:0] other_cell;
      logic [SlotBits-1:0]  face_slot;
      status_type           status;
   } face_outcome_type;

   class cell_assembly_board;
      logic [FieldBits-1:0] cell_id;
      int unsigned          faces_seen;
      cell_nodes_type       verts;
      bit                   slot_used [NumSlots];
      face_outcome_type     awaited [$];
      int unsigned          errors;
      int unsigned          checked;
      int unsigned          cells_done;
      int unsigned          status_seen [16];

      function new();
         restart(CellIndexReset);
      endfunction

      function void restart(logic [FieldBits-1:0] id);
         int i;
         cell_id = id;
         faces_seen = 0;
         verts = '0;
         for (i = 0; i < NumSlots; i++) slot_used[i] = 1'b0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function int turn(int i, bit ahead);
         return (i + (ahead ? 1 : 3)) % FaceNodes;
      endfunction

      function bit locate(face_ring_type n, logic [FieldBits-1:0] v, output int pos);
         int i;
         pos = 0;
         for (i = 0; i < FaceNodes; i++) begin
            if (n[i] == v) begin
               pos = i;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function status_type place_face(face_item_type f, output logic [SlotBits-1:0] slot,
                                      output logic [FieldBits-1:0] far);
         face_ring_type        n;
         bit                   own;
         bit                   two;
         int                   i;
         int                   cnt;
         int                   p;
         int                   q;
         int                   va;
         int                   vb;
         logic [FieldBits-1:0] xa;
         logic [FieldBits-1:0] xb;
         n = {f.node_d, f.node_c, f.node_b, f.node_a};
         slot = '0;
         far = '0;
         two = 1'b0;
         cnt = 0;
         va = 0;
         vb = 0;
         xa = '0;
         xb = '0;
         if (!f.is_quad) return ST_NOT_QUAD;
         if (cell_id != f.owner_cell && cell_id != f.neighbour_cell) return ST_NOT_ADJ;
         if (faces_seen >= NumSlots) return ST_OVER_SIX;
         own = (cell_id == f.owner_cell);
         far = own ? f.neighbour_cell : f.owner_cell;
         if (faces_seen == 0) begin
            verts = '0;
            verts[0] = n[0];
            verts[7] = n[2];
            verts[3] = own ? n[1] : n[3];
            verts[4] = own ? n[3] : n[1];
            for (i = 0; i < NumSlots; i++) slot_used[i] = 1'b0;
            slot = 0;
         end else begin
            for (i = 0; i < FaceNodes; i++) begin
               if (n[i] == verts[0] || n[i] == verts[3] || n[i] == verts[7] ||
                   n[i] == verts[4])
                  cnt++;
            end
            if (cnt == 0) begin
               slot = 1;
            end else if (cnt != 2) begin
               return ST_NO_MATCH;
            end else begin
               two = 1'b1;
               if (locate(n, verts[0], p)) begin
                  if (locate(n, verts[4], q)) begin
                     slot = 2; va = 5; vb = 1;
                     xa = n[turn(q, own)];
                     xb = n[turn(p, !own)];
                  end else if (locate(n, verts[3], q)) begin
                     slot = 4; va = 1; vb = 2;
                     xa = n[turn(p, own)];
                     xb = n[turn(q, !own)];
                  end else begin
                     return ST_PAIR_MISSING;
                  end
               end else if (locate(n, verts[7], p)) begin
                  if (locate(n, verts[4], q)) begin
                     slot = 5; va = 6; vb = 5;
                     xa = n[turn(p, own)];
                     xb = n[turn(q, !own)];
                  end else if (locate(n, verts[3], q)) begin
                     slot = 3; va = 2; vb = 6;
                     xa = n[turn(q, own)];
                     xb = n[turn(p, !own)];
                  end else begin
                     return ST_PAIR_MISSING;
                  end
               end else begin
                  return ST_BAD_CONN;
               end
               if (!(verts[va] == 0 || verts[va] == xa) ||
                   !(verts[vb] == 0 || verts[vb] == xb))
                  return ST_CLASH;
            end
            if (slot_used[slot]) return ST_DUP;
            if (two) begin
               if (verts[va] == 0) verts[va] = xa;
               if (verts[vb] == 0) verts[vb] = xb;
            end
         end
         slot_used[slot] = 1'b1;
         faces_seen++;
         return ST_OK;
      endfunction

      function void note_face(face_item_type f);
         face_outcome_type o;
         o.status = place_face(f, o.face_slot, o.other_cell);
         if (o.status != ST_OK) begin
            o.face_slot = '0;
            o.other_cell = '0;
         end else if (faces_seen == NumSlots) begin
            cells_done++;
         end
         o.complete = (faces_seen == NumSlots);
         o.verts = verts;
         status_seen[o.status]++;
         awaited.insert(awaited.size(), o);
      endfunction

      task report(string what, logic [FieldBits-1:0] got, logic [FieldBits-1:0] want);
         errors++;
         if (errors <= MaxPrinted)
            $display("MISMATCH %s: got %h, want %h (result %0d)", what, got, want, checked);
      endtask

      task check_result(face_outcome_type r);
         face_outcome_type w;
         int i;
         checked++;
         if (awaited.size() == 0) begin
            report("result with nothing awaited", r.status, '0);
            return;
         end
         w = awaited.pop_front();
         if (r.status !== w.status) report("status", r.status, w.status);
         if (r.face_slot !== w.face_slot) report("face_slot", r.face_slot, w.face_slot);
         if (r.other_cell !== w.other_cell) report("other_cell", r.other_cell, w.other_cell);
         if (r.complete !== w.complete) report("complete", r.complete, w.complete);
         for (i = 0; i < NumVerts; i++) begin
            if (r.verts[i] !== w.verts[i])
               report($sformatf("vert%0d", i), r.verts[i], w.verts[i]);
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [FieldBits-1:0]   csr_wr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // face_id, is_quad, owner_cell, neighbour_cell, node_a..node_d, zero pad
   logic [ReqDataBits-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // status, face_slot, other_cell, complete, vert0..vert7
   logic [RspDataBits-1:0] rsp_tdata;

   logic                   rsp_hold = 1'b0;
   int                     send_idle_pct = 0;
   int                     recv_stall_pct = 0;
   int                     quiet_cycles = 0;
   int unsigned            faces_driven = 0;
   int unsigned            cell_writes = 0;

   cell_assembly_board board = new();

   hex_cell_vertex_assembler uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(face_outcome_type'(rsp_tdata));
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic face_ring_type face_ring(cell_nodes_type v, int slot);
      case (slot)
         1: begin
            return {v[2], v[6], v[5], v[1]};
         end
         2: begin
            return {v[1], v[5], v[4], v[0]};
         end
         3: begin
            return {v[7], v[6], v[2], v[3]};
         end
         4: begin
            return {v[3], v[2], v[1], v[0]};
         end
         5: begin
            return {v[4], v[5], v[6], v[7]};
         end
         default: begin
            return {v[4], v[7], v[3], v[0]};
         end
      endcase
   endfunction

   function automatic logic [FieldBits-1:0] pick_far(logic [FieldBits-1:0] cid);
      case ($urandom_range(15))
         0, 1: begin
            return '0;
         end
         2: begin
            return cid;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   function automatic logic [FieldBits-1:0] pick_cell_index();
      case ($urandom_range(15))
         0: begin
            return '1;
         end
         1: begin
            return 32'd1;
         end
         2: begin
            return '0;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // own keeps the ring's turning sense, otherwise walk it backwards
   function automatic face_item_type make_face(logic [FieldBits-1:0] cid, face_ring_type ring,
                                               bit own, int rot, logic [FieldBits-1:0] far);
      face_item_type f;
      face_ring_type n;
      int            i;
      for (i = 0; i < FaceNodes; i++)
         n[i] = own ? ring[(i + rot) % FaceNodes] : ring[(FaceNodes - i + rot) % FaceNodes];
      f.face_id = $urandom;
      f.is_quad = 1'b1;
      f.owner_cell = own ? cid : far;
      f.neighbour_cell = own ? far : cid;
      f.node_a = n[0];
      f.node_b = n[1];
      f.node_c = n[2];
      f.node_d = n[3];
      return f;
   endfunction

   function automatic face_item_type faulty_face(logic [FieldBits-1:0] cid, cell_nodes_type v);
      face_item_type        f;
      face_ring_type        ring;
      logic [FieldBits-1:0] x;
      logic [FieldBits-1:0] y;
      int                   kind;
      x = $urandom;
      y = $urandom;
      kind = $urandom_range(7);
      ring = face_ring(v, $urandom_range(1, 5));
      case (kind)
         2: begin
            ring = {$urandom, y, $urandom, x};
         end
         3: begin
            ring = {y, v[7], x, v[0]};
         end
         4: begin
            ring = {y, v[4], x, v[3]};
         end
         5: begin
            ring = {x, v[7], v[3], v[0]};
         end
         6: begin
            ring = face_ring(v, $urandom_range(2, 5));
            ring[2] = x;
         end
         default: begin
         end
      endcase
      f = make_face(cid, ring, $urandom_range(1), $urandom_range(3), pick_far(cid));
      if (kind == 0) f.is_quad = 1'b0;
      if (kind == 1) begin
         f.owner_cell = cid + 32'd1 + $urandom_range(1000);
         f.neighbour_cell = cid + 32'd2 + $urandom_range(1000);
      end
      return f;
   endfunction

   task automatic send_face(input face_item_type f);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 50) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ReqDataBits'(f);
      do @(posedge clock); while (!req_tready);
      faces_driven++;
      board.note_face(f);
   endtask

   task automatic write_cell_index(input logic [FieldBits-1:0] value);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.restart(value);
      cell_writes++;
   endtask

   task automatic assemble_cell(input logic [FieldBits-1:0] cid, input int fault_pct,
                                input bit squeeze);
      cell_nodes_type v;
      int             order [5];
      int             k;
      int             j;
      int             t;
      bit             small_set;
      write_cell_index(cid);
      if (squeeze) begin
         fork
            begin
               rsp_hold <= 1'b1;
               repeat (PressureCycles) @(posedge clock);
               rsp_hold <= 1'b0;
            end
         join_none
      end
      small_set = ($urandom_range(9) == 0);
      for (k = 0; k < NumVerts; k++) v[k] = small_set ? $urandom_range(1, 12) : $urandom;
      for (k = 0; k < 5; k++) order[k] = k + 1;
      for (k = 4; k > 0; k--) begin
         j = $urandom_range(k);
         t = order[k];
         order[k] = order[j];
         order[j] = t;
      end
      send_face(make_face(cid, face_ring(v, 0), $urandom_range(1), 0, pick_far(cid)));
      for (k = 0; k < 5; k++) begin
         if ($urandom_range(99) < fault_pct) send_face(faulty_face(cid, v));
         send_face(make_face(cid, face_ring(v, order[k]), $urandom_range(1),
                             $urandom_range(3), pick_far(cid)));
      end
      if ($urandom_range(3) == 0)
         send_face(make_face(cid, face_ring(v, $urandom_range(1, 5)), $urandom_range(1),
                             $urandom_range(3), pick_far(cid)));
   endtask

   initial begin
      cell_nodes_type hv;
      cell_nodes_type zw;
      face_ring_type  ring;
      face_item_type  f;
      int             k;
      int             phase;
      bit             squeezed;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      hv[0] = 32'd1;
      hv[1] = 32'h5555_5555;
      hv[2] = 32'h8000_0000;
      hv[3] = 32'd2;
      hv[4] = 32'h7FFF_FFFF;
      hv[5] = 32'd3;
      hv[6] = 32'hAAAA_AAAA;
      hv[7] = 32'hFFFF_FFFF;

      // cell one straight out of reset: shape beats adjacency, then every rejection
      f = make_face(32'd1, face_ring(hv, 0), 1'b1, 0, 32'd9);
      f.owner_cell = 32'd7;
      f.is_quad = 1'b0;
      send_face(f);
      f = make_face(32'd1, face_ring(hv, 0), 1'b1, 0, 32'd8);
      f.owner_cell = 32'd7;
      send_face(f);
      f = make_face(32'd1, face_ring(hv, 0), 1'b1, 0, '1);
      f.face_id = '1;
      send_face(f);
      send_face(make_face(32'd1, {32'd102, 32'd101, 32'd100, hv[0]}, 1'b1, 0, 32'd5));
      send_face(make_face(32'd1, {32'd101, hv[7], 32'd100, hv[0]}, 1'b1, 0, 32'd5));
      send_face(make_face(32'd1, {32'd101, hv[4], 32'd100, hv[3]}, 1'b1, 0, 32'd5));
      send_face(make_face(32'd1, face_ring(hv, 2), 1'b0, 1, '1));
      ring = face_ring(hv, 4);
      ring[1] = 32'd104;
      send_face(make_face(32'd1, ring, 1'b1, 0, 32'd6));
      ring = face_ring(hv, 2);
      ring[2] = 32'd105;
      send_face(make_face(32'd1, ring, 1'b1, 0, 32'd6));
      send_face(make_face(32'd1, face_ring(hv, 2), 1'b1, 2, 32'd6));
      send_face(make_face(32'd1, face_ring(hv, 4), 1'b1, 3, 32'd6));
      send_face(make_face(32'd1, face_ring(hv, 3), 1'b1, 0, 32'd1));
      send_face(make_face(32'd1, face_ring(hv, 5), 1'b0, 1, 32'd6));
      send_face(make_face(32'd1, face_ring(hv, 1), 1'b1, 0, '0));
      send_face(make_face(32'd1, face_ring(hv, 2), 1'b1, 0, 32'd6));

      // cell zero on boundary faces, a repeated node and a zero node
      for (k = 0; k < NumVerts; k++) zw[k] = 32'd10 + k;
      zw[1] = '0;
      write_cell_index('0);
      send_face(make_face('0, {zw[4], zw[0], zw[3], zw[0]}, 1'b1, 0, '0));
      send_face(make_face('0, face_ring(zw, 2), 1'b1, 0, '0));
      send_face(make_face('0, face_ring(zw, 4), 1'b1, 1, '0));

      assemble_cell('1, 0, 1'b0);

      squeezed = 1'b0;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 60;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 60;
            end
            default: begin
               send_idle_pct = 15;
               recv_stall_pct = 15;
            end
         endcase
         while (faces_driven < (phase + 1) * ItemsPerPhase) begin
            assemble_cell(pick_cell_index(), FaultPct, phase == 0 && !squeezed);
            squeezed = 1'b1;
         end
      end

      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("Covered %0d faces over %0d cell index writes: %0d results checked, %0d cells built.",
               faces_driven, cell_writes, board.checked, board.cells_done);
      $display("Status mix: ok %0d, not quad %0d, not adjacent %0d, over six %0d, pair %0d,",
               board.status_seen[ST_OK], board.status_seen[ST_NOT_QUAD],
               board.status_seen[ST_NOT_ADJ], board.status_seen[ST_OVER_SIX],
               board.status_seen[ST_PAIR_MISSING]);
      $display("   clash %0d, connectivity %0d, no match %0d, duplicate %0d",
               board.status_seen[ST_CLASH], board.status_seen[ST_BAD_CONN],
               board.status_seen[ST_NO_MATCH], board.status_seen[ST_DUP]);
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/hcva_pkg.sv
design/hcva_classify.sv
design/hcva_state.sv
design/hex_cell_vertex_assembler.sv
verif/hex_cell_vertex_assembler_test.sv
